@@ rtl/core/imuldi_pkg.sv @@
// shared types, constants and microcode table for the leaky double integrator
// no dependencies; imported by the channel interfaces and the top level
package imuldi_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int GAIN_WIDTH   = 16;
    localparam int STEP_WIDTH   = 24;
    localparam int ACC_WIDTH    = SAMPLE_WIDTH + 1;
    localparam int OPB_WIDTH    = STEP_WIDTH + 1;
    localparam int PROD_WIDTH   = ACC_WIDTH + OPB_WIDTH;
    localparam int RND_WIDTH    = SAMPLE_WIDTH + 2;
    localparam int NUM_AXES     = 3;
    localparam int CFG_WIDTH    = STEP_WIDTH;

    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd65375;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = 24'd65536;

    localparam logic signed [PROD_WIDTH-1:0] HALF_STEP = PROD_WIDTH'(1) << (STEP_WIDTH - 1);
    localparam logic signed [PROD_WIDTH-1:0] HALF_GAIN = PROD_WIDTH'(1) << (GAIN_WIDTH - 1);

    // register indexes
    localparam logic REG_LEAK_GAIN = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    // microcode addresses
    localparam logic [3:0] UPC_FIRST = 4'd0;
    localparam logic [3:0] UPC_EMIT  = 4'd8;
    localparam logic [1:0] LAST_AXIS = 2'(NUM_AXES - 1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] accel_x;
        logic signed [SAMPLE_WIDTH-1:0] accel_y;
        logic signed [SAMPLE_WIDTH-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] vel_x;
        logic signed [SAMPLE_WIDTH-1:0] vel_y;
        logic signed [SAMPLE_WIDTH-1:0] vel_z;
        logic signed [SAMPLE_WIDTH-1:0] pos_x;
        logic signed [SAMPLE_WIDTH-1:0] pos_y;
        logic signed [SAMPLE_WIDTH-1:0] pos_z;
    } result_t;

    typedef enum logic [1:0] {MA_ACCEL, MA_ACC, MA_VEL} mul_a_t;
    typedef enum logic {MB_STEP, MB_GAIN} mul_b_t;
    typedef enum logic {RND_STEP, RND_GAIN} rnd_t;
    typedef enum logic {ADD_VEL, ADD_POS} add_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_AXIS, SEQ_EMIT} seq_t;

    typedef struct packed {
        mul_a_t mul_a;
        mul_b_t mul_b;
        rnd_t   rnd;
        add_t   add_src;
        logic   acc_en;
        logic   vel_wr;
        logic   pos_wr;
        seq_t   seq;
    } ctrl_t;

    // one axis: v = k*(v + a*dt), p = k*(p + v*dt), multiply and round alternate
    function automatic ctrl_t ucode(input logic [3:0] upc);
        ctrl_t c;
        c = '{mul_a: MA_ACCEL, mul_b: MB_STEP, rnd: RND_STEP, add_src: ADD_VEL,
              acc_en: 1'b0, vel_wr: 1'b0, pos_wr: 1'b0, seq: SEQ_NEXT};
        unique case (upc)
            4'd0: begin c.mul_a = MA_ACCEL; c.mul_b = MB_STEP; end
            4'd1: begin c.rnd = RND_STEP; c.add_src = ADD_VEL; c.acc_en = 1'b1; end
            4'd2: begin c.mul_a = MA_ACC; c.mul_b = MB_GAIN; end
            4'd3: begin c.rnd = RND_GAIN; c.vel_wr = 1'b1; end
            4'd4: begin c.mul_a = MA_VEL; c.mul_b = MB_STEP; end
            4'd5: begin c.rnd = RND_STEP; c.add_src = ADD_POS; c.acc_en = 1'b1; end
            4'd6: begin c.mul_a = MA_ACC; c.mul_b = MB_GAIN; end
            4'd7: begin c.rnd = RND_GAIN; c.pos_wr = 1'b1; c.seq = SEQ_AXIS; end
            default: c.seq = SEQ_EMIT;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/imuldi_if.sv @@
// valid/ready channel interfaces for acceleration samples and filtered results
// depends on imuldi_pkg for the payload types
interface imuldi_sample_if import imuldi_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface imuldi_result_if import imuldi_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/imu_leaky_double_integrator_unit.sv @@
// leaky double integrator: microcoded sequencer around one shared 33x25 multiplier
// program: 8 steps per axis over 3 axes, then an emit step that loads the output register
// a new sample waits for the last one's emit step; four multiplies per axis share the one unit
// the output register lets the next sample run while a result waits to be taken
// reset: asynchronous active low; velocity and position clear to zero, gain 65375, dt 65536
// depends on imuldi_pkg and imuldi_if
module imu_leaky_double_integrator_unit import imuldi_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [CFG_WIDTH-1:0] wr_data,
    imuldi_sample_if.sink        sample,
    imuldi_result_if.source      result
);

    // configuration registers
    logic [GAIN_WIDTH-1:0] leak_gain_reg;
    logic [STEP_WIDTH-1:0] time_step_reg;

    // sequencer state
    logic       busy_reg, busy_next;
    logic [3:0] upc_reg, upc_next;
    logic [1:0] axis_reg, axis_next;
    ctrl_t      ctrl;

    // datapath
    logic signed [SAMPLE_WIDTH-1:0] accel_reg [NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] vel_reg [NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] pos_reg [NUM_AXES];
    logic signed [ACC_WIDTH-1:0]    acc_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;

    logic signed [ACC_WIDTH-1:0]    mul_a;
    logic signed [OPB_WIDTH-1:0]    mul_b;
    logic signed [PROD_WIDTH-1:0]   sum_step, sum_gain;
    logic signed [RND_WIDTH-1:0]    rounded;
    logic signed [RND_WIDTH-1:0]    acc_sum;
    logic signed [SAMPLE_WIDTH-1:0] addend;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;

    // output stage
    logic    out_valid_reg;
    logic    out_load;
    result_t out_payload_reg;

    logic sample_take;

    assign sample.ready = !busy_reg;
    assign sample_take  = sample.valid && !busy_reg;
    assign ctrl         = ucode(upc_reg);

    // configuration writes, out-of-range bits dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_gain_reg <= GAIN_RESET;
            time_step_reg <= STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LEAK_GAIN: leak_gain_reg <= wr_data[GAIN_WIDTH-1:0];
                REG_TIME_STEP: time_step_reg <= wr_data[STEP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // step counter with axis loop and emit wait
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        axis_next = axis_reg;
        out_load  = 1'b0;
        if (sample_take)
        begin
            busy_next = 1'b1;
            upc_next  = UPC_FIRST;
            axis_next = '0;
        end
        else if (busy_reg)
        begin
            unique case (ctrl.seq)
                SEQ_NEXT: upc_next = upc_reg + 4'd1;
                SEQ_AXIS:
                begin
                    if (axis_reg == LAST_AXIS)
                    begin
                        upc_next  = UPC_EMIT;
                        axis_next = '0;
                    end
                    else
                    begin
                        upc_next  = UPC_FIRST;
                        axis_next = axis_reg + 2'd1;
                    end
                end
                SEQ_EMIT:
                begin
                    // hold here until the output register is free
                    if (!out_valid_reg || result.ready)
                    begin
                        out_load  = 1'b1;
                        busy_next = 1'b0;
                        upc_next  = UPC_FIRST;
                    end
                end
                default: upc_next = UPC_EMIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= UPC_FIRST;
            axis_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            axis_reg <= axis_next;
        end
    end

    // input sample latch
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            accel_reg[0] <= sample.payload.accel_x;
            accel_reg[1] <= sample.payload.accel_y;
            accel_reg[2] <= sample.payload.accel_z;
        end
    end

    // shared multiplier operands; dt and k are unsigned, so a zero sign bit goes on top
    always_comb
    begin
        unique case (ctrl.mul_a)
            MA_ACCEL: mul_a = ACC_WIDTH'(accel_reg[axis_reg]);
            MA_ACC:   mul_a = acc_reg;
            MA_VEL:   mul_a = ACC_WIDTH'(vel_reg[axis_reg]);
            default:  mul_a = acc_reg;
        endcase
        unique case (ctrl.mul_b)
            MB_STEP: mul_b = $signed({1'b0, time_step_reg});
            MB_GAIN: mul_b = $signed({{(OPB_WIDTH - GAIN_WIDTH){1'b0}}, leak_gain_reg});
            default: mul_b = $signed({1'b0, time_step_reg});
        endcase
    end

    // product registered before rounding
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // round half up: add half an lsb, keep the bits above the binary point
    assign sum_step = prod_reg + HALF_STEP;
    assign sum_gain = prod_reg + HALF_GAIN;

    always_comb
    begin
        unique case (ctrl.rnd)
            RND_STEP: rounded = sum_step[STEP_WIDTH +: RND_WIDTH];
            RND_GAIN: rounded = sum_gain[GAIN_WIDTH +: RND_WIDTH];
            default:  rounded = sum_gain[GAIN_WIDTH +: RND_WIDTH];
        endcase
    end

    // integration add: previous state plus the dt term, exact in 33 bits
    assign addend  = (ctrl.add_src == ADD_POS) ? pos_reg[axis_reg] : vel_reg[axis_reg];
    assign acc_sum = RND_WIDTH'(addend) + rounded;

    // clamp the leaked value to the signed sample range
    always_comb
    begin
        if (rounded[RND_WIDTH-1:SAMPLE_WIDTH-1] == '0
            || rounded[RND_WIDTH-1:SAMPLE_WIDTH-1] == '1)
        begin
            sat_val = rounded[SAMPLE_WIDTH-1:0];
        end
        else if (rounded[RND_WIDTH-1])
        begin
            sat_val = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_sum[ACC_WIDTH-1:0];
        end
    end

    // filter state, per axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (ctrl.vel_wr)
            begin
                vel_reg[axis_reg] <= sat_val;
            end
            if (ctrl.pos_wr)
            begin
                pos_reg[axis_reg] <= sat_val;
            end
        end
    end

    // output register, decouples the result transaction from the next sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_payload_reg.vel_x <= vel_reg[0];
            out_payload_reg.vel_y <= vel_reg[1];
            out_payload_reg.vel_z <= vel_reg[2];
            out_payload_reg.pos_x <= pos_reg[0];
            out_payload_reg.pos_y <= pos_reg[1];
            out_payload_reg.pos_z <= pos_reg[2];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

`ifndef SYNTHESIS
    // the axis counter never leaves the three axes
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    // a new result only appears after the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(upc_reg) == UPC_EMIT)
        else $error("result raised outside the emit step");

    // an accepted sample starts the program at its first step on the first axis
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> busy_reg && upc_reg == UPC_FIRST && axis_reg == '0)
        else $error("sequencer did not start on a sample transaction");

    // a pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !out_load)
        else $error("result overwritten while stalled");
`endif

endmodule

@@ dv/imu_leaky_double_integrator_unit_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the leaky double integrator: directed and random samples
// depends on imuldi_pkg, imuldi_if and imu_leaky_double_integrator_unit

module imu_leaky_double_integrator_unit_test import imuldi_pkg::*; ();

    // wide signed scratch type, enough for a 64-bit sum times a 24-bit factor
    typedef logic signed [127:0] wide_t;

    // receiver stall patterns, picked by the receiver itself
    typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_SPARSE, DRAIN_PERIODIC} drain_mode_t;

    localparam int LATENCY     = 25;
    localparam int SETTLE      = 2 * LATENCY;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_ITEMS  = 24;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 118;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [SAMPLE_WIDTH-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] ACC_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_WIDTH-1:0] ACC_ONE = 32'sh0001_0000;
    localparam logic [GAIN_WIDTH-1:0]          GAIN_FULL = 16'hFFFF;
    localparam logic [STEP_WIDTH-1:0]          STEP_FULL = 24'hFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic                 wr_index;
    logic [CFG_WIDTH-1:0] wr_data;

    imuldi_sample_if sample_ch ();
    imuldi_result_if result_ch ();

    imu_leaky_double_integrator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (sample_ch),
        .result   (result_ch)
    );

    // mirror of the block's registers and per-axis filter state
    logic [GAIN_WIDTH-1:0]          gain_cfg;
    logic [STEP_WIDTH-1:0]          step_cfg;
    logic signed [SAMPLE_WIDTH-1:0] vel_state [NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] pos_state [NUM_AXES];

    // motion results still owed by the block, oldest first
    result_t pending_motion [$];

    int error_count   = 0;
    int hold_request  = 0;
    int cycle_count   = 0;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("imu_leaky_double_integrator_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------

    // x * m / 2^n, rounded half toward +infinity
    function automatic wide_t round_shift(input wide_t x, input logic [STEP_WIDTH-1:0] m,
                                          input int unsigned n);
        wide_t m_wide;
        wide_t prod;
        m_wide = {104'd0, m};
        prod   = x * m_wide + (wide_t'(1) <<< (n - 1));
        return prod >>> n;
    endfunction

    // clamp to a signed w-bit range
    function automatic wide_t clamp_to(input wide_t x, input int unsigned w);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // one sample through all three axes: v = k*(v + a*dt), then p = k*(p + v*dt)
    function automatic result_t integrate_sample(input sample_t s);
        logic signed [SAMPLE_WIDTH-1:0] accel [NUM_AXES];
        wide_t   a_wide;
        wide_t   v_wide;
        wide_t   p_wide;
        wide_t   sum;
        result_t r;
        accel[0] = s.accel_x;
        accel[1] = s.accel_y;
        accel[2] = s.accel_z;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a_wide = accel[i];
            v_wide = vel_state[i];
            p_wide = pos_state[i];
            // integration sum kept exact, only bounded at 64 bits
            sum    = clamp_to(v_wide + round_shift(a_wide, step_cfg, STEP_WIDTH), 64);
            v_wide = clamp_to(round_shift(sum, {8'd0, gain_cfg}, GAIN_WIDTH), SAMPLE_WIDTH);
            // position uses the freshly updated velocity
            sum    = clamp_to(p_wide + round_shift(v_wide, step_cfg, STEP_WIDTH), 64);
            p_wide = clamp_to(round_shift(sum, {8'd0, gain_cfg}, GAIN_WIDTH), SAMPLE_WIDTH);
            vel_state[i] = v_wide[SAMPLE_WIDTH-1:0];
            pos_state[i] = p_wide[SAMPLE_WIDTH-1:0];
        end
        r.vel_x = vel_state[0];
        r.vel_y = vel_state[1];
        r.vel_z = vel_state[2];
        r.pos_x = pos_state[0];
        r.pos_y = pos_state[1];
        r.pos_z = pos_state[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: stall patterns and the long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_drain
        int          hold_left;
        int          mode_left;
        int          period;
        int          tick;
        drain_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        period    = 2;
        tick      = 0;
        mode      = DRAIN_FREE;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            // a hold-off request from the test sequence takes priority
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            // pick a new random stall pattern and period when the current pattern runs out
            if (mode_left == 0)
            begin
                mode      = drain_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
                period    = $urandom_range(2, 29);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    DRAIN_FREE:     result_ch.ready <= 1'b1;
                    DRAIN_RANDOM:   result_ch.ready <= 1'($urandom_range(0, 1));
                    DRAIN_SPARSE:   result_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:        result_ch.ready <= ((tick % period) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [SAMPLE_WIDTH-1:0] want,
                               input logic signed [SAMPLE_WIDTH-1:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d actual %0d", name, want, got);
        end
    endtask

    // every accepted result transaction is compared against the oldest prediction
    always @(posedge clk)
    begin : motion_check
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_motion.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result transaction with nothing expected: %p", result_ch.payload);
            end
            else
            begin
                want = pending_motion.pop_front();
                check_field("vel_x", want.vel_x, result_ch.payload.vel_x);
                check_field("vel_y", want.vel_y, result_ch.payload.vel_y);
                check_field("vel_z", want.vel_z, result_ch.payload.vel_z);
                check_field("pos_x", want.pos_x, result_ch.payload.pos_x);
                check_field("pos_y", want.pos_y, result_ch.payload.pos_y);
                check_field("pos_z", want.pos_z, result_ch.payload.pos_z);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic sample_t make_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                                            input logic signed [SAMPLE_WIDTH-1:0] y,
                                            input logic signed [SAMPLE_WIDTH-1:0] z);
        sample_t s;
        s.accel_x = x;
        s.accel_y = y;
        s.accel_z = z;
        return s;
    endfunction

    // mostly realistic magnitudes, some full-range words, some extremes
    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_accel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
        if (pick < 8)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return ACC_MAX;
            1:       return ACC_MIN;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic [GAIN_WIDTH-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return GAIN_FULL;
            1:       return '0;
            2:       return 16'd1;
            3:       return 16'd32768;
            4:       return GAIN_RESET;
            default: return GAIN_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [STEP_WIDTH-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return STEP_FULL;
            1:       return 24'd1;
            2:       return '0;
            3:       return STEP_RESET;
            4:       return STEP_WIDTH'($urandom_range(1, 4096));
            default: return STEP_WIDTH'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    // register write, starts on a fresh edge so back-to-back writes never collide
    task automatic write_register(input logic index, input logic [CFG_WIDTH-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
        // bits above the register width are dropped by the block
        if (index == REG_LEAK_GAIN)
            gain_cfg = data[GAIN_WIDTH-1:0];
        else
            step_cfg = data[STEP_WIDTH-1:0];
    endtask

    // offer one sample, leave valid high so the next one can follow without a gap
    task automatic send_sample(input sample_t s);
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= s;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        pending_motion = {pending_motion, integrate_sample(s)};
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop offering, let every owed result come back, then let the block settle
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_motion.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset gain and step, zero state, field extremes
    task automatic test_reset_defaults();
        send_sample(make_sample('0, '0, '0));
        send_sample(make_sample(ACC_MAX, ACC_MIN, 1));
        send_sample(make_sample(-1, ACC_MIN, ACC_MAX));
        wait_drained();
    endtask

    // unity-ish gain and the longest step drive velocity and position into saturation
    task automatic test_saturation();
        write_register(REG_LEAK_GAIN, {8'd0, GAIN_FULL});
        write_register(REG_TIME_STEP, STEP_FULL);
        repeat (4) send_sample(make_sample(ACC_MAX, ACC_MIN, 32'sh4000_0000));
        send_sample(make_sample(ACC_MIN, ACC_MAX, -1));
        send_sample(make_sample(ACC_MIN, ACC_MAX, '0));
        wait_drained();
    endtask

    // zero gain clears the state every step; the upper data bits must be ignored
    task automatic test_zero_gain();
        write_register(REG_LEAK_GAIN, 24'hAB_0000);
        send_sample(make_sample(ACC_MAX, ACC_MIN, ACC_ONE));
        send_sample(make_sample(ACC_ONE, -ACC_ONE, ACC_MAX));
        send_sample(make_sample('0, '0, '0));
        wait_drained();
    endtask

    // build up some state, then a zero time step leaves only the decay
    task automatic test_zero_step();
        write_register(REG_LEAK_GAIN, 24'hFF_FFFF);
        write_register(REG_TIME_STEP, STEP_RESET);
        send_sample(make_sample(32'sh0050_0000, -32'sh0030_0000, ACC_ONE));
        send_sample(make_sample(32'sh0050_0000, -32'sh0030_0000, ACC_ONE));
        wait_drained();
        write_register(REG_LEAK_GAIN, {8'd0, GAIN_RESET});
        write_register(REG_TIME_STEP, '0);
        send_sample(make_sample(ACC_MAX, ACC_MIN, ACC_MAX));
        send_sample(make_sample(ACC_MIN, ACC_MAX, ACC_MIN));
        send_sample(make_sample('0, '0, '0));
        wait_drained();
    endtask

    // smallest nonzero step: products round to tiny values
    task automatic test_min_step();
        write_register(REG_TIME_STEP, 24'd1);
        send_sample(make_sample(ACC_MAX, ACC_MIN, 32'sh0080_0000));
        send_sample(make_sample(ACC_MIN, ACC_MAX, -32'sh0080_0000));
        wait_drained();
    endtask

    // receiver holds off for a long stretch while samples keep coming,
    // so the block fills and has to stall its input; then the sender
    // pauses until every result has come back
    task automatic test_receiver_hold();
        write_register(REG_LEAK_GAIN, {8'd0, GAIN_RESET});
        write_register(REG_TIME_STEP, STEP_RESET);
        hold_request = LONG_HOLD;
        repeat (HOLD_ITEMS) send_sample(make_sample(rand_accel(), rand_accel(), rand_accel()));
        wait_drained();
    endtask

    // several register settings, bursts of random samples with random gaps
    task automatic test_random_phases();
        logic [GAIN_WIDTH-1:0] gain;
        logic [STEP_WIDTH-1:0] dt;
        int                    sent;
        int                    burst;
        bit                    gapless;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // the first phases pin the register extremes, the rest are random
            if (ph == 0)
            begin
                gain = GAIN_FULL;
                dt   = STEP_FULL;
            end
            else if (ph == 1)
            begin
                gain = '0;
                dt   = 24'd1;
            end
            else
            begin
                gain = pick_gain();
                dt   = pick_step();
            end
            write_register(REG_LEAK_GAIN, {8'($urandom), gain});
            write_register(REG_TIME_STEP, dt);
            // every fourth phase runs with no sender gaps at all
            gapless = ((ph % 4) == 3);
            sent    = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 16);
                repeat (burst)
                begin
                    send_sample(make_sample(rand_accel(), rand_accel(), rand_accel()));
                    sent++;
                end
                if (!gapless && ($urandom_range(0, 2) != 0))
                    pause_sender($urandom_range(1, 30));
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        sample_ch.valid   <= 1'b0;
        sample_ch.payload <= '0;
        wr_en             <= 1'b0;
        wr_index          <= REG_LEAK_GAIN;
        wr_data           <= '0;
        rst_n             <= 1'b0;
        gain_cfg = GAIN_RESET;
        step_cfg = STEP_RESET;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            vel_state[i] = '0;
            pos_state[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation();
        test_zero_gain();
        test_zero_step();
        test_min_step();
        test_receiver_hold();
        test_random_phases();

        wait_drained();
        if (error_count == 0)
            $display("imu_leaky_double_integrator_unit test passed");
        else
            $display("imu_leaky_double_integrator_unit test failed");
        $finish;
    end

endmodule
